/* rtl/arq_pkg.sv */
// ----------------------------------------------------------------------------
// arq_pkg
// Shared types, constants and helpers of the ARQ sender window engine.
// ----------------------------------------------------------------------------
`default_nettype none

package arq_pkg;

  localparam int WINDOW_CAP = 16;
  localparam int SEQ_BITS   = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_BITS  = $clog2(WINDOW_CAP);
  localparam int CNT_BITS   = $clog2(WINDOW_CAP + 1);
  localparam int WIN_BITS   = 5;
  localparam int TMO_BITS   = 16;
  localparam int EST_BITS   = 20;
  localparam int MARGIN_BITS = 10;
  localparam int CWND_MAX   = (WINDOW_CAP < 16) ? WINDOW_CAP : 16;
  localparam logic [EST_BITS-1:0] EST_MAX = '1;

  localparam int RST_WINDOW = 4;
  localparam int RST_RTT    = 1000;
  localparam int RST_MARGIN = 15;
  localparam int RST_TMO    = ((RST_RTT + 8 * RST_RTT) >> 3) + RST_MARGIN;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] CFG_INITIAL_WINDOW = 2'd0;
  localparam logic [1:0] CFG_INITIAL_RTT    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_MARGIN = 2'd2;

  localparam logic [2:0] RES_SENT    = 3'd0;
  localparam logic [2:0] RES_REFUSED = 3'd1;
  localparam logic [2:0] RES_ACKED   = 3'd2;
  localparam logic [2:0] RES_IGNORED = 3'd3;
  localparam logic [2:0] RES_RETX    = 3'd4;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SEQ_BITS-1:0] seq;
  } qitem_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SEQ_BITS-1:0] seq;
    logic [WIN_BITS-1:0] window_size;
    logic [SEQ_BITS-1:0] window_base;
    logic [TMO_BITS-1:0] timeout;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [TMO_BITS-1:0]  timeout;
    logic [TIME_BITS-1:0] sent_at;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST1,
    ST_EST2,
    ST_SLIDE,
    ST_EMIT_ACK,
    ST_T_RD,
    ST_T_CHK,
    ST_R_RD,
    ST_R_WR
  } state_t;

  function automatic logic [WIN_BITS-1:0] clamp_window(input logic [WIN_BITS:0] v);
    logic [WIN_BITS-1:0] r;
    if (v == '0) begin
      r = WIN_BITS'(1);
    end else if (v > (WIN_BITS + 1)'(CWND_MAX)) begin
      r = WIN_BITS'(CWND_MAX);
    end else begin
      r = v[WIN_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/arq_sender_window_engine.sv */
// ----------------------------------------------------------------------------
// arq_sender_window_engine
// Sender side of a selective-repeat ARQ with AIMD window and RTT timer.
//
// Input stream s_*: tuser holds the kind (send, ack, tick), tdata the acked
// sequence number. Items with an unknown kind are dropped. A two-entry queue
// sits between the input decoder and the window sequencer.
// Result stream m_*: one registered result; tlast marks the last result of
// an input item. A tick with no expired entry gives no result.
// A send or an ignored ack loads its result in the idle state. A taken ack
// runs estimator states EST1 and EST2 (skipped when a resent entry lies at or
// below it in the window), slides the base over each acked entry and emits.
// A tick walks the outstanding entries through the single entry memory read
// port until one has expired, then reads and resends each unacked entry in
// turn. Other items finish in the idle state. A stalled m_tready holds the
// sequencer before its next result; the queue keeps taking items until full.
// cfg_* writes are taken at any time and are meant for idle periods. Reset
// clears control state but not the acked and resent flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_sender_window_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [1:0]                   s_tuser,   // kind
  input  wire logic [15:0]                  s_tdata,   // ack_seq
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [2:0]                        m_tuser,   // result_kind
  output logic [55:0]                       m_tdata,   // seq, window_size, window_base, timeout_ms, pad
  output logic                              m_tlast,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data
);

  logic             q_valid;
  logic             q_pop;
  arq_pkg::qitem_t  q_head;
  arq_pkg::result_t res;

  arq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  arq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign cfg_ready = 1'b1;
  assign m_tuser   = res.kind;
  assign m_tlast   = res.last;
  assign m_tdata   = {3'b000, res.timeout, res.window_base, res.window_size, res.seq};

endmodule

`default_nettype wire

/* rtl/arq_front.sv */
// ----------------------------------------------------------------------------
// arq_front
// Accepts input items, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [1:0]                    s_tuser,  // kind
  input  wire logic [arq_pkg::SEQ_BITS-1:0]  s_tdata,  // ack_seq
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output arq_pkg::qitem_t                    q_head
);

  arq_pkg::qitem_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            known;
  logic            push;
  arq_pkg::qitem_t item;

  always_comb begin
    known   = 1'b1;
    item.seq = s_tdata;
    unique case (s_tuser)
      arq_pkg::KIND_SEND: item.op = arq_pkg::OP_SEND;
      arq_pkg::KIND_ACK:  item.op = arq_pkg::OP_ACK;
      arq_pkg::KIND_TICK: item.op = arq_pkg::OP_TICK;
      default: begin
        item.op = arq_pkg::OP_TICK;
        known   = 1'b0;
      end
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready && known;
  assign q_valid  = (count != 2'd0);
  assign q_head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/arq_back.sv */
// ----------------------------------------------------------------------------
// arq_back
// Window sequencer: sends, acks with RTT estimation, tick scan and resend.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire arq_pkg::qitem_t              q_head,
  input  wire logic                         cfg_valid,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output arq_pkg::result_t                  out_res
);

  localparam int SB = arq_pkg::SLOT_BITS;
  localparam int CB = arq_pkg::CNT_BITS;
  localparam int QB = arq_pkg::SEQ_BITS;
  localparam int TB = arq_pkg::TIME_BITS;
  localparam int WB = arq_pkg::WIN_BITS;
  localparam int EB = arq_pkg::EST_BITS;

  arq_pkg::state_t state, state_next;

  logic [TB-1:0]  now_ms;
  logic [QB-1:0]  base;
  logic [QB-1:0]  next_seq;
  logic [WB-1:0]  cwnd;
  logic [WB-1:0]  credit;
  logic           avoid;
  logic [EB-1:0]  est;
  logic [EB-1:0]  dev;
  logic [15:0]    tmo;
  logic [arq_pkg::MARGIN_BITS-1:0] margin;
  logic [arq_pkg::WINDOW_CAP-1:0]  acked;
  logic [arq_pkg::WINDOW_CAP-1:0]  resent;
  logic [QB-1:0]  cur_seq;
  logic [CB-1:0]  idx;
  logic [EB-1:0]  samp;
  logic [EB-1:0]  diff;

  arq_pkg::entry_t mem [arq_pkg::WINDOW_CAP];
  arq_pkg::entry_t rd_data;
  arq_pkg::entry_t wr_data;
  logic [SB-1:0]   rd_addr;
  logic [SB-1:0]   wr_addr;
  logic            mem_we;

  logic [QB-1:0]  outst;
  logic [CB-1:0]  cnt;
  logic           out_free;
  logic           out_load;
  arq_pkg::result_t res;
  logic [QB-1:0]  ack_off;
  logic [SB-1:0]  ack_slot;
  logic           ack_bad;
  logic           dirty;
  logic [SB-1:0]  scan_slot;
  logic           more;
  logic           expired_hit;
  logic [TB-1:0]  since;
  logic [TB-1:0]  age;
  logic [16:0]    dbl;
  logic [15:0]    dbl_sat;
  logic [EB-1:0]  samp_c;
  logic [EB+2:0]  dev_sum;
  logic [EB+2:0]  est_sum;
  logic [EB+2:0]  tmo_base;
  logic [EB+1:0]  tmo_full;
  logic [SB-1:0]  rel [arq_pkg::WINDOW_CAP];

  assign outst     = next_seq - base;
  assign cnt       = outst[CB-1:0];
  assign out_free  = !out_valid || out_ready;
  assign ack_off   = q_head.seq - base;
  assign ack_slot  = q_head.seq[SB-1:0];
  assign ack_bad   = (ack_off >= outst) || acked[ack_slot];
  assign scan_slot = base[SB-1:0] + idx[SB-1:0];
  assign since     = now_ms - rd_data.deadline;
  assign expired_hit = !acked[scan_slot] && !since[TB-1];
  assign dbl       = {rd_data.timeout, 1'b0};
  assign dbl_sat   = dbl[16] ? 16'hFFFF : dbl[15:0];
  assign age       = now_ms - rd_data.sent_at;
  assign samp_c    = (age[TB-1:EB-3] != '0) ? arq_pkg::EST_MAX : {age[EB-4:0], 3'b000};
  assign dev_sum   = (EB+3)'(dev) + (EB+3)'({dev, 1'b0}) + (EB+3)'(diff);
  assign est_sum   = (EB+3)'({est, 3'b000}) - (EB+3)'(est) + (EB+3)'(samp);
  assign tmo_base  = (EB+3)'(est) + (EB+3)'({dev, 2'b00});
  assign tmo_full  = (EB+2)'(tmo_base[EB+2:3]) + (EB+2)'(margin);

  always_comb begin
    dirty = 1'b0;
    more  = 1'b0;
    for (int j = 0; j < arq_pkg::WINDOW_CAP; j++) begin
      rel[j] = SB'(j) - base[SB-1:0];
      if (QB'(rel[j]) <= ack_off && resent[j]) begin
        dirty = 1'b1;
      end
      if (CB'(rel[j]) > idx && CB'(rel[j]) < cnt && !acked[j]) begin
        more = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      arq_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          unique case (q_head.op)
            arq_pkg::OP_SEND: state_next = arq_pkg::ST_IDLE;
            arq_pkg::OP_ACK: begin
              if (ack_bad) state_next = arq_pkg::ST_IDLE;
              else if (dirty) state_next = arq_pkg::ST_SLIDE;
              else state_next = arq_pkg::ST_EST1;
            end
            arq_pkg::OP_TICK: begin
              if (cnt != '0) state_next = arq_pkg::ST_T_RD;
            end
            default: state_next = arq_pkg::ST_IDLE;
          endcase
        end
      end
      arq_pkg::ST_EST1:     state_next = arq_pkg::ST_EST2;
      arq_pkg::ST_EST2:     state_next = arq_pkg::ST_SLIDE;
      arq_pkg::ST_SLIDE: begin
        if (!(outst != '0 && acked[base[SB-1:0]])) state_next = arq_pkg::ST_EMIT_ACK;
      end
      arq_pkg::ST_EMIT_ACK: begin
        if (out_free) state_next = arq_pkg::ST_IDLE;
      end
      arq_pkg::ST_T_RD:     state_next = arq_pkg::ST_T_CHK;
      arq_pkg::ST_T_CHK: begin
        if (expired_hit) state_next = arq_pkg::ST_R_RD;
        else if (idx + CB'(1) == cnt) state_next = arq_pkg::ST_IDLE;
        else state_next = arq_pkg::ST_T_RD;
      end
      arq_pkg::ST_R_RD: begin
        if (idx >= cnt) state_next = arq_pkg::ST_IDLE;
        else if (!acked[scan_slot]) state_next = arq_pkg::ST_R_WR;
      end
      arq_pkg::ST_R_WR: begin
        if (out_free) state_next = more ? arq_pkg::ST_R_RD : arq_pkg::ST_IDLE;
      end
      default: state_next = arq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = next_seq[SB-1:0];
    wr_data.deadline = now_ms + TB'(tmo);
    wr_data.timeout  = tmo;
    wr_data.sent_at  = now_ms;
    rd_addr  = scan_slot;
    res.kind        = arq_pkg::RES_SENT;
    res.seq         = next_seq;
    res.window_size = cwnd;
    res.window_base = base;
    res.timeout     = tmo;
    res.last        = 1'b1;
    unique case (state)
      arq_pkg::ST_IDLE: begin
        rd_addr = ack_slot;
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            arq_pkg::OP_SEND: begin
              out_load = 1'b1;
              if (outst >= QB'(cwnd)) begin
                res.kind    = arq_pkg::RES_REFUSED;
                res.timeout = '0;
              end else begin
                mem_we = 1'b1;
              end
            end
            arq_pkg::OP_ACK: begin
              if (ack_bad) begin
                out_load    = 1'b1;
                res.kind    = arq_pkg::RES_IGNORED;
                res.seq     = q_head.seq;
                res.timeout = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      arq_pkg::ST_EMIT_ACK: begin
        out_load = out_free;
        res.kind = arq_pkg::RES_ACKED;
        res.seq  = cur_seq;
      end
      arq_pkg::ST_R_WR: begin
        out_load = out_free;
        mem_we   = out_free;
        wr_addr  = scan_slot;
        wr_data.deadline = now_ms + TB'(dbl_sat);
        wr_data.timeout  = dbl_sat;
        wr_data.sent_at  = rd_data.sent_at;
        res.kind    = arq_pkg::RES_RETX;
        res.seq     = base + QB'(idx);
        res.timeout = dbl_sat;
        res.last    = !more;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
    samp <= samp_c;
    diff <= (samp_c > est) ? samp_c - est : est - samp_c;
    if (q_pop) begin
      cur_seq <= q_head.seq;
    end
    if (q_pop && q_head.op == arq_pkg::OP_SEND && mem_we) begin
      acked[next_seq[SB-1:0]]  <= 1'b0;
      resent[next_seq[SB-1:0]] <= 1'b0;
    end
    if (q_pop && q_head.op == arq_pkg::OP_ACK && !ack_bad) begin
      acked[ack_slot] <= 1'b1;
    end
    if (state == arq_pkg::ST_R_WR && out_free) begin
      resent[scan_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= arq_pkg::ST_IDLE;
      out_valid <= 1'b0;
      now_ms    <= '0;
      base      <= '0;
      next_seq  <= '0;
      cwnd      <= WB'(arq_pkg::RST_WINDOW);
      credit    <= WB'(arq_pkg::RST_WINDOW);
      avoid     <= 1'b0;
      est       <= EB'(arq_pkg::RST_RTT);
      dev       <= EB'(2 * arq_pkg::RST_RTT);
      margin    <= arq_pkg::MARGIN_BITS'(arq_pkg::RST_MARGIN);
      tmo       <= 16'(arq_pkg::RST_TMO);
      idx       <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      tmo <= (tmo_full[EB+1:16] != '0) ? 16'hFFFF : tmo_full[15:0];

      if (cfg_valid) begin
        unique case (cfg_index)
          arq_pkg::CFG_INITIAL_WINDOW: begin
            cwnd   <= arq_pkg::clamp_window({1'b0, cfg_data[WB-1:0]});
            credit <= arq_pkg::clamp_window({1'b0, cfg_data[WB-1:0]});
          end
          arq_pkg::CFG_INITIAL_RTT: begin
            est <= EB'(cfg_data);
            dev <= EB'({cfg_data, 1'b0});
          end
          arq_pkg::CFG_TIMEOUT_MARGIN: margin <= cfg_data[arq_pkg::MARGIN_BITS-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        arq_pkg::ST_IDLE: begin
          idx <= '0;
          if (mem_we) next_seq <= next_seq + QB'(1);
          if (q_pop && q_head.op == arq_pkg::OP_TICK) now_ms <= now_ms + TB'(1);
        end
        arq_pkg::ST_EST2: begin
          dev <= dev_sum[EB+1:2];
          est <= est_sum[EB+2:3];
        end
        arq_pkg::ST_SLIDE: begin
          if (outst != '0 && acked[base[SB-1:0]]) begin
            base <= base + QB'(1);
            if (credit != '0) credit <= credit - WB'(1);
          end else if (credit == '0) begin
            cwnd   <= arq_pkg::clamp_window(avoid ? {1'b0, cwnd} + (WB+1)'(1) : {cwnd, 1'b0});
            credit <= arq_pkg::clamp_window(avoid ? {1'b0, cwnd} + (WB+1)'(1) : {cwnd, 1'b0});
          end
        end
        arq_pkg::ST_T_CHK: begin
          if (expired_hit) begin
            idx    <= '0;
            cwnd   <= arq_pkg::clamp_window({2'b00, cwnd[WB-1:1]});
            credit <= arq_pkg::clamp_window({2'b00, cwnd[WB-1:1]});
            avoid  <= 1'b1;
          end else begin
            idx <= idx + CB'(1);
          end
        end
        arq_pkg::ST_R_RD: begin
          if (idx < cnt && acked[scan_slot]) idx <= idx + CB'(1);
        end
        arq_pkg::ST_R_WR: begin
          if (out_free) idx <= idx + CB'(1);
        end
        default: begin
        end
      endcase
    end
  end

  a_outstanding_bound: assert property (@(posedge clk) disable iff (rst)
    outst <= QB'(arq_pkg::WINDOW_CAP))
    else $error("outstanding count beyond window capacity");

  a_cwnd_range: assert property (@(posedge clk) disable iff (rst)
    cwnd != '0 && cwnd <= WB'(arq_pkg::CWND_MAX) && credit <= cwnd)
    else $error("window or credit out of range");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == arq_pkg::ST_IDLE && out_free)
    else $error("item taken while busy");

  a_retx_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == arq_pkg::ST_R_RD && $past(state) == arq_pkg::ST_T_CHK) |-> avoid)
    else $error("resend pass without congestion avoidance");

endmodule

`default_nettype wire

/* verif/arq_sender_window_engine_tb.sv */
// ----------------------------------------------------------------------------
// arq_sender_window_engine_tb
// Self-checking bench for the ARQ sender window engine. Sends, acks, ticks
// and unknown kinds go in over the input stream in random bursts. A local
// model of the window, the RTT estimator and the retransmit scan predicts
// every result; results are checked field by field against it, while the
// result side stalls at random and once holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_sender_window_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] ack_seq;
  } ev_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = arq_pkg::KIND_SEND;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [2:0]  m_tuser;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = arq_pkg::CFG_INITIAL_WINDOW;
  logic [15:0] cfg_data = '0;

  arq_sender_window_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model of the sender
  logic [4:0]  cfg_win;
  logic [15:0] cfg_rtt;
  logic [9:0]  cfg_margin;
  logic [31:0] now_ms;
  logic [15:0] base_seq, next_seq;
  logic [4:0]  cwnd;
  logic [5:0]  credit;
  bit          avoiding;
  logic [19:0] rtt_est, rtt_dev;
  logic [15:0] tmo_iv;
  logic [31:0] e_deadline [arq_pkg::WINDOW_CAP];
  logic [15:0] e_timeout  [arq_pkg::WINDOW_CAP];
  logic [31:0] e_sent_at  [arq_pkg::WINDOW_CAP];
  bit          e_acked    [arq_pkg::WINDOW_CAP];
  bit          e_resent   [arq_pkg::WINDOW_CAP];

  ev_t              pending_q[$];
  arq_pkg::result_t expected_q[$];
  int      n_items, n_results, n_retx, n_refused, n_ignored, n_mismatch;
  int      cyc;
  bit      drv_en;
  bit      hold_req;

  function automatic logic [4:0] win_clamp(int v);
    if (v < 1) return 5'd1;
    if (v > arq_pkg::CWND_MAX) return 5'(arq_pkg::CWND_MAX);
    return 5'(v);
  endfunction

  function automatic void update_timeout();
    longint t;
    t = ((longint'(rtt_est) + 4 * longint'(rtt_dev)) >> 3) + cfg_margin;
    tmo_iv = (t > 65535) ? 16'hFFFF : 16'(t);
  endfunction

  function automatic void seed_rtt();
    rtt_est = 20'(cfg_rtt);
    rtt_dev = 20'(2 * int'(cfg_rtt));
    update_timeout();
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [15:0] v);
    case (idx)
      arq_pkg::CFG_INITIAL_WINDOW: begin
        cfg_win = v[4:0];
        cwnd = win_clamp(cfg_win);
        credit = 6'(cwnd);
      end
      arq_pkg::CFG_INITIAL_RTT: begin
        cfg_rtt = v;
        seed_rtt();
      end
      arq_pkg::CFG_TIMEOUT_MARGIN: begin
        cfg_margin = v[9:0];
        update_timeout();
      end
      default: ;
    endcase
  endfunction

  function automatic arq_pkg::result_t mk_result(logic [2:0] k, logic [15:0] s,
                                                 logic [15:0] t);
    arq_pkg::result_t r;
    r.kind = k;
    r.seq = s;
    r.window_size = cwnd;
    r.window_base = base_seq;
    r.timeout = t;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_step(logic [1:0] kind, logic [15:0] aseq);
    arq_pkg::result_t outs[$];
    logic [15:0] outst, off, s;
    logic [3:0]  sl;
    logic [31:0] sample;
    logic [31:0] since;
    logic [19:0] smp8, diff;
    bit          clean, expired;
    int          t;
    outst = next_seq - base_seq;
    case (kind)
      arq_pkg::KIND_SEND: begin
        if (outst >= 16'(cwnd)) begin
          outs.push_back(mk_result(arq_pkg::RES_REFUSED, next_seq, 16'd0));
        end else begin
          sl = next_seq[3:0];
          e_timeout[sl] = tmo_iv;
          e_sent_at[sl] = now_ms;
          e_deadline[sl] = now_ms + 32'(tmo_iv);
          e_acked[sl] = 0;
          e_resent[sl] = 0;
          s = next_seq;
          next_seq = next_seq + 16'd1;
          outs.push_back(mk_result(arq_pkg::RES_SENT, s, tmo_iv));
        end
      end
      arq_pkg::KIND_ACK: begin
        off = aseq - base_seq;
        sl = aseq[3:0];
        if (off >= outst || e_acked[sl]) begin
          outs.push_back(mk_result(arq_pkg::RES_IGNORED, aseq, 16'd0));
        end else begin
          e_acked[sl] = 1;
          clean = 1;
          for (int i = 0; i <= int'(off); i++)
            if (e_resent[4'(base_seq + 16'(i))]) clean = 0;
          if (clean) begin
            sample = now_ms - e_sent_at[sl];
            smp8 = (sample > 32'd131071) ? 20'hFFFFF : 20'(sample * 8);
            diff = (smp8 > rtt_est) ? smp8 - rtt_est : rtt_est - smp8;
            rtt_dev = 20'((3 * longint'(rtt_dev) + diff) >> 2);
            rtt_est = 20'((7 * longint'(rtt_est) + smp8) >> 3);
            update_timeout();
          end
          while (next_seq != base_seq && e_acked[base_seq[3:0]]) begin
            base_seq = base_seq + 16'd1;
            if (credit > 0) credit = credit - 6'd1;
          end
          if (credit == 0) begin
            cwnd = win_clamp(avoiding ? int'(cwnd) + 1 : int'(cwnd) * 2);
            credit = 6'(cwnd);
          end
          outs.push_back(mk_result(arq_pkg::RES_ACKED, aseq, tmo_iv));
        end
      end
      arq_pkg::KIND_TICK: begin
        now_ms = now_ms + 32'd1;
        expired = 0;
        for (int i = 0; i < int'(outst); i++) begin
          sl = 4'(base_seq + 16'(i));
          since = now_ms - e_deadline[sl];
          if (!e_acked[sl] && !since[31]) expired = 1;
        end
        if (expired) begin
          cwnd = win_clamp(int'(cwnd) / 2);
          credit = 6'(cwnd);
          avoiding = 1;
          for (int i = 0; i < int'(outst) && outs.size() < 16; i++) begin
            s = base_seq + 16'(i);
            sl = s[3:0];
            if (!e_acked[sl]) begin
              t = int'(e_timeout[sl]) * 2;
              if (t > 65535) t = 65535;
              e_timeout[sl] = 16'(t);
              e_deadline[sl] = now_ms + 32'(t);
              e_resent[sl] = 1;
              outs.push_back(mk_result(arq_pkg::RES_RETX, s, 16'(t)));
            end
          end
        end
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_q.push_back(outs[i]);
  endfunction

  function automatic void model_reset();
    cfg_win = 5'(arq_pkg::RST_WINDOW);
    cfg_rtt = 16'(arq_pkg::RST_RTT);
    cfg_margin = 10'(arq_pkg::RST_MARGIN);
    now_ms = '0;
    base_seq = '0;
    next_seq = '0;
    cwnd = win_clamp(cfg_win);
    credit = 6'(cwnd);
    avoiding = 0;
    seed_rtt();
    for (int i = 0; i < arq_pkg::WINDOW_CAP; i++) begin
      e_deadline[i] = '0;
      e_timeout[i] = '0;
      e_sent_at[i] = '0;
      e_acked[i] = 0;
      e_resent[i] = 0;
    end
  endfunction

  // input driver
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    bit busy;
    ev_t ev;
    busy = s_tvalid;
    if (s_tvalid && s_tready) begin
      predict_step(s_tuser, s_tdata);
      n_items++;
      busy = 0;
    end
    if (!busy) begin
      if (rst || !drv_en) begin
        s_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        ev = pending_q.pop_front();
        s_tuser <= ev.kind;
        s_tdata <= ev.ack_seq;
        s_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side: stall pattern plus one long hold-off
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    arq_pkg::result_t got, want;
    cyc <= cyc + 1;
    if (m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.seq = m_tdata[15:0];
      got.window_size = m_tdata[20:16];
      got.window_base = m_tdata[36:21];
      got.timeout = m_tdata[52:37];
      got.last = m_tlast;
      n_results++;
      if (got.kind == arq_pkg::RES_RETX) n_retx++;
      if (got.kind == arq_pkg::RES_REFUSED) n_refused++;
      if (got.kind == arq_pkg::RES_IGNORED) n_ignored++;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (rst || hold_left > 0) begin
      m_tready <= 1'b0;
    end else if (((cyc >> 7) & 3) == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results pending", cyc, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic add(logic [1:0] k, logic [15:0] a);
    ev_t ev;
    ev.kind = k;
    ev.ack_seq = a;
    pending_q.push_back(ev);
  endtask

  // random traffic shaped around the model's current window
  task automatic run_random(int count);
    int   r;
    logic [15:0] outst;
    for (int n = 0; n < count; n++) begin
      while (pending_q.size() >= 2) @(posedge clk);
      outst = next_seq - base_seq;
      r = $urandom_range(0, 99);
      if (r < 38) add(arq_pkg::KIND_SEND, 16'($urandom));
      else if (r < 62)
        add(arq_pkg::KIND_ACK, base_seq + 16'($urandom_range(0, int'(outst))));
      else if (r < 68) add(arq_pkg::KIND_ACK, 16'($urandom));
      else if (r < 95) add(arq_pkg::KIND_TICK, 16'($urandom));
      else add(2'd3, 16'($urandom));
    end
  endtask

  initial begin
    model_reset();
    drv_en = 0;
    hold_req = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    drv_en = 1;

    // defaults: fill the window, refuse, acks in and out of range
    repeat (5) add(arq_pkg::KIND_SEND, 16'h0000);
    add(arq_pkg::KIND_ACK, 16'h0000);
    add(arq_pkg::KIND_ACK, 16'h0000);
    add(arq_pkg::KIND_ACK, 16'hFFFF);
    add(arq_pkg::KIND_ACK, 16'h0002);
    add(arq_pkg::KIND_ACK, 16'h0001);
    add(2'd3, 16'hFFFF);
    add(arq_pkg::KIND_TICK, 16'h0000);
    wait_idle();

    // largest window, saturated timeout
    cfg_write(arq_pkg::CFG_INITIAL_WINDOW, 16'd16);
    cfg_write(arq_pkg::CFG_INITIAL_RTT, 16'd60000);
    cfg_write(arq_pkg::CFG_TIMEOUT_MARGIN, 16'd1000);
    repeat (17) add(arq_pkg::KIND_SEND, 16'h0);
    add(arq_pkg::KIND_ACK, 16'h0005);
    wait_idle();

    // short timeouts for the sends that follow, then three ticks
    cfg_write(arq_pkg::CFG_INITIAL_RTT, 16'd1);
    cfg_write(arq_pkg::CFG_TIMEOUT_MARGIN, 16'd0);
    repeat (3) add(arq_pkg::KIND_TICK, 16'h0);
    wait_idle();

    cfg_write(arq_pkg::CFG_INITIAL_WINDOW, 16'd1);
    run_random(100);
    wait_idle();

    cfg_write(arq_pkg::CFG_INITIAL_WINDOW, 16'd16);
    cfg_write(arq_pkg::CFG_INITIAL_RTT, 16'd3);
    cfg_write(arq_pkg::CFG_TIMEOUT_MARGIN, 16'd2);
    run_random(40);
    hold_req = 1;
    run_random(70);
    wait_idle();

    cfg_write(arq_pkg::CFG_INITIAL_WINDOW, 16'($urandom_range(2, 15)));
    cfg_write(arq_pkg::CFG_INITIAL_RTT, 16'($urandom_range(1, 8)));
    cfg_write(arq_pkg::CFG_TIMEOUT_MARGIN, 16'($urandom_range(0, 3)));
    run_random(110);
    wait_idle();

    cfg_write(arq_pkg::CFG_INITIAL_WINDOW, 16'd8);
    cfg_write(arq_pkg::CFG_INITIAL_RTT, 16'd2);
    cfg_write(arq_pkg::CFG_TIMEOUT_MARGIN, 16'd1);
    run_random(100);
    wait_idle();

    $display("covered %0d input items giving %0d results: %0d retransmits, %0d refused sends,",
             n_items, n_results, n_retx, n_refused);
    $display("%0d ignored acks, window settings from 1 to 16, %0d mismatches",
             n_ignored, n_mismatch);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/arq_pkg.sv
rtl/arq_front.sv
rtl/arq_back.sv
rtl/arq_sender_window_engine.sv
verif/arq_sender_window_engine_tb.sv
